// ===== hw/rtl/msvf_pkg.sv =====
// Package for the slot volume fade engine: ops, widths, attenuation table.
// Used by the front, back and top level files.
`timescale 1ns / 1ps
`default_nettype none
package msvf_pkg;

  localparam int SLOTS_DEF     = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CNT_W         = 18;
  localparam int FRM_W         = 16;

  typedef enum logic [2:0] {
    OP_SET      = 3'd0,
    OP_SET_CEIL = 3'd1,
    OP_FADE_REQ = 3'd2,
    OP_FADE_BTW = 3'd3,
    OP_TICK     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    FM_NONE = 2'd0,
    FM_CEIL = 2'd1,
    FM_MUTE = 2'd2,
    FM_KEEP = 2'd3
  } fade_mode_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DECODE,
    BK_DIV,
    BK_TICK,
    BK_EMIT
  } bk_state_t;

  // Queued request between front and back.
  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  slot;
    logic [7:0]  level;
    logic [7:0]  ceiling_level;
    logic [1:0]  fade_mode;
    logic [15:0] frames;
    logic [7:0]  first_level;
    logic [7:0]  start_level;
    logic [7:0]  end_level;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  out_slot;
    logic [10:0] attenuation;
    logic        level_written;
    logic        stop_stream;
    logic        fade_busy;
    logic        last;
  } res_t;

  function automatic logic signed [10:0] att_lookup(input logic [6:0] idx);
    logic signed [10:0] a;
    begin
      if (idx < 7'd32)       a = -11'sd2 * $signed({4'd0, idx});
      else if (idx < 7'd64)  a = -11'sd64 - 11'sd6 * $signed({4'd0, idx - 7'd32});
      else if (idx < 7'd96)  a = -11'sd256 - 11'sd8 * $signed({4'd0, idx - 7'd64});
      else if (idx == 7'd127) a = -11'sd999;
      else                   a = -11'sd512 - 11'sd16 * $signed({4'd0, idx - 7'd96});
      return a;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/msvf_req_if.sv =====
// Input and result channel interfaces: valid, ready and the payloads.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface msvf_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [1:0]  slot;
  logic [7:0]  level;
  logic [7:0]  ceiling_level;
  logic [1:0]  fade_mode;
  logic [15:0] duration_centisec;
  logic [7:0]  first_level;
  logic [7:0]  start_level;
  logic [7:0]  end_level;
  logic [15:0] frame_count;
  modport source (output valid, op, slot, level, ceiling_level, fade_mode,
                  duration_centisec, first_level, start_level, end_level,
                  frame_count, input ready);
  modport sink (input valid, op, slot, level, ceiling_level, fade_mode,
                duration_centisec, first_level, start_level, end_level,
                frame_count, output ready);
endinterface

interface msvf_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_slot;
  logic [10:0] attenuation;
  logic        level_written;
  logic        stop_stream;
  logic        fade_busy;
  logic        last;
  modport source (output valid, out_slot, attenuation, level_written, stop_stream,
                  fade_busy, last, input ready);
  modport sink (input valid, out_slot, attenuation, level_written, stop_stream,
                fade_busy, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/multi_slot_volume_fade_engine.sv =====
// Slot volume fade engine. Ops 0/1 update a slot and emit one result;
// ops 2/3 run the serial divider (one bit a cycle; op 3 with zero frames skips it);
// a tick walks every slot, then emits one result per fading slot.
// The back end takes a new request from the queue only once it is idle again.
// Reset (rst_n low at a clock edge) zeroes all slot state, stops fades,
// sets hr_r to all ones and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module multi_slot_volume_fade_engine #(
  parameter int SLOTS     = msvf_pkg::SLOTS_DEF,
  parameter int FRAC_BITS = msvf_pkg::FRAC_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  msvf_req_if.sink        in_ch,
  msvf_res_if.source      out_ch
);

  logic           q_valid, q_ready;
  msvf_pkg::req_t q_data;
  msvf_pkg::res_t res;

  msvf_front #(.SLOTS(SLOTS)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.op),
    .in_slot(in_ch.slot), .in_level(in_ch.level),
    .in_ceiling_level(in_ch.ceiling_level), .in_fade_mode(in_ch.fade_mode),
    .in_duration_centisec(in_ch.duration_centisec),
    .in_first_level(in_ch.first_level), .in_start_level(in_ch.start_level),
    .in_end_level(in_ch.end_level), .in_frame_count(in_ch.frame_count),
    .q_valid, .q_ready, .q_data
  );

  msvf_back #(.SLOTS(SLOTS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .q_valid, .q_ready, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(res)
  );

  // Drive the result transfer payload.
  assign out_ch.out_slot      = res.out_slot;
  assign out_ch.attenuation   = res.attenuation;
  assign out_ch.level_written = res.level_written;
  assign out_ch.stop_stream   = res.stop_stream;
  assign out_ch.fade_busy     = res.fade_busy;
  assign out_ch.last          = res.last;

endmodule
`default_nettype wire

// ===== hw/rtl/msvf_front.sv =====
// Front end: accepts requests, drops invalid ones, converts centiseconds
// to frames and queues the request. Depends on msvf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msvf_front #(
  parameter int SLOTS = msvf_pkg::SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       in_op,
  input  wire logic [1:0]       in_slot,
  input  wire logic [7:0]       in_level,
  input  wire logic [7:0]       in_ceiling_level,
  input  wire logic [1:0]       in_fade_mode,
  input  wire logic [15:0]      in_duration_centisec,
  input  wire logic [7:0]       in_first_level,
  input  wire logic [7:0]       in_start_level,
  input  wire logic [7:0]       in_end_level,
  input  wire logic [15:0]      in_frame_count,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output msvf_pkg::req_t        q_data
);

  // Stage 1 registers: raw request plus centisecond split.
  logic           s1_valid_r, s1_valid_nxt;
  msvf_pkg::req_t s1_req_r;
  logic [9:0]     s1_hund_r;   // t / 100
  logic [6:0]     s1_rem_r;    // t % 100
  logic [1:0]     q_cnt_r;
  msvf_pkg::req_t q_mem_r [2];
  logic           q_wr_r, q_rd_r;

  logic           keep;
  logic [9:0]     quo_est;
  logic [16:0]    rem_est;
  logic [9:0]     rem6;
  logic [16:0]    tenth_prod;
  logic [16:0]    frames_sum;
  logic [15:0]    frames;
  msvf_pkg::req_t q_in;
  logic           push, pop;

  assign keep = (in_op == msvf_pkg::OP_TICK) ||
                ((32'(in_slot) < SLOTS) && (in_op < msvf_pkg::OP_TICK));

  // Divide by 100 with reciprocal 5243 >> 19; the estimate is high by at most one.
  assign quo_est = 10'((32'(in_duration_centisec) * 32'd5243) >> 19);
  assign rem_est = 17'(in_duration_centisec) - 17'(quo_est) * 17'd100;

  assign in_ready = !s1_valid_r || push;
  assign push     = s1_valid_r && (q_cnt_r != 2'd2);
  assign pop      = q_valid && q_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (push) s1_valid_nxt = 1'b0;
    if (in_valid && in_ready && keep) s1_valid_nxt = 1'b1;
  end

  // Frames from the split duration; remainder * 6 / 10 via reciprocal 205 >> 11.
  assign rem6       = 10'(s1_rem_r) * 10'd6;
  assign tenth_prod = 17'(rem6) * 17'd205;
  assign frames_sum = (17'(s1_hund_r) * 17'd30 + 17'(tenth_prod[16:11])) >> 1;
  always_comb begin
    frames = frames_sum[15:0];
    if (s1_req_r.op == msvf_pkg::OP_FADE_REQ && frames == 16'd0) frames = 16'd1;
  end

  // Queue entry: timed fades carry the converted frame count.
  always_comb begin
    q_in = s1_req_r;
    if (s1_req_r.op == msvf_pkg::OP_FADE_REQ) q_in.frames = frames;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_valid && in_ready) begin
      s1_req_r.op            <= in_op;
      s1_req_r.slot          <= in_slot;
      s1_req_r.level         <= in_level;
      s1_req_r.ceiling_level <= in_ceiling_level;
      s1_req_r.fade_mode     <= in_fade_mode;
      s1_req_r.frames        <= in_frame_count;
      s1_req_r.first_level   <= in_first_level;
      s1_req_r.start_level   <= in_start_level;
      s1_req_r.end_level     <= in_end_level;
      if (rem_est[16]) begin
        s1_hund_r <= quo_est - 10'd1;
        s1_rem_r  <= 7'(rem_est + 17'd100);
      end else begin
        s1_hund_r <= quo_est;
        s1_rem_r  <= 7'(rem_est);
      end
    end
  end

  // Two-entry queue to the back end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
    end else begin
      if (push) q_wr_r <= !q_wr_r;
      if (pop)  q_rd_r <= !q_rd_r;
      q_cnt_r <= 2'(q_cnt_r + {1'b0, push} - {1'b0, pop});
    end
    if (push) begin
      q_mem_r[q_wr_r] <= q_in;
    end
  end

  assign q_valid = (q_cnt_r != 2'd0);
  assign q_data  = q_mem_r[q_rd_r];

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd2) |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_cnt_r != 2'd0)) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== hw/rtl/msvf_back.sv =====
// Back end: slot state, serial divider for fade steps, tick walk and
// result register. Depends on msvf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msvf_back #(
  parameter int SLOTS     = msvf_pkg::SLOTS_DEF,
  parameter int FRAC_BITS = msvf_pkg::FRAC_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [3:0]      cfg_wdata,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire msvf_pkg::req_t  q_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output msvf_pkg::res_t       out_data
);

  localparam int LW  = FRAC_BITS + 9;         // level width
  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW  = LW + 1;                // dividend magnitude width
  localparam int DCW = $clog2(DW + 1);
  localparam logic signed [LW-1:0] LMIN = LW'(-(128 <<< FRAC_BITS));
  localparam logic signed [LW-1:0] LMAX = LW'((128 <<< FRAC_BITS) - 1);

  logic signed [LW-1:0]        lvl_r [SLOTS];
  logic signed [LW-1:0]        tgt_r [SLOTS];
  logic signed [LW-1:0]        stp_r [SLOTS];
  logic signed [LW-1:0]        ceil_r [SLOTS];
  logic signed [msvf_pkg::CNT_W-1:0] cnt_r [SLOTS];
  logic [1:0]                  mode_r [SLOTS];
  logic [3:0]                  hr_r;

  msvf_pkg::bk_state_t st_r, st_nxt;
  msvf_pkg::req_t      req_r;
  logic [SW-1:0]       ws_r;          // walk slot
  logic                busy_r;
  logic [SLOTS-1:0]    rep_r, stop_r; // slots reported by this request, stop flags
  logic [SW:0]         es_r;          // emit slot index
  msvf_pkg::res_t      res_r;
  logic                res_v_r;

  // Divider state.
  logic [DW-1:0]       dq_r;
  logic [msvf_pkg::FRM_W:0] drem_r;
  logic [DCW-1:0]      dcnt_r;
  logic                dneg_r;
  logic [SW-1:0]       dslot_r;

  logic [SW-1:0]       rs;
  logic signed [LW-1:0] nl_sub;
  logic signed [LW+1:0] diff_w;
  logic                emit_one, emit_pending;
  logic [SW-1:0]       es_idx;
  logic [msvf_pkg::FRM_W:0] dtrial;

  assign rs = SW'(req_r.slot);

  function automatic logic signed [LW-1:0] from_int(input logic [7:0] v);
    return LW'($signed({{(LW-8){v[7]}}, v}) <<< FRAC_BITS);
  endfunction

  function automatic logic signed [8:0] trunc_i(input logic signed [LW-1:0] v);
    logic [LW-1:0] m;
    begin
      m = v[LW-1] ? LW'(-v) : v;
      m = m >> FRAC_BITS;
      return v[LW-1] ? -$signed(9'(m)) : $signed(9'(m));
    end
  endfunction

  function automatic logic [10:0] att_of(input logic signed [LW-1:0] v,
                                        input logic is0);
    logic signed [LW:0]  n;
    logic [LW:0]         ix;
    logic [6:0]          id;
    logic signed [11:0]  a;
    begin
      n  = -$signed({v[LW-1], v});
      ix = (n <= 0) ? '0 : (LW+1)'(n >>> FRAC_BITS);
      id = (ix > (LW+1)'(127)) ? 7'd127 : ix[6:0];
      a  = 12'(msvf_pkg::att_lookup(id));
      if (is0) begin
        a = a - 12'sd25;
        if (a < -12'sd960) a = -12'sd960;
      end
      return a[10:0];
    end
  endfunction

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      msvf_pkg::BK_IDLE:   if (q_valid) st_nxt = msvf_pkg::BK_DECODE;
      msvf_pkg::BK_DECODE: begin
        priority if (req_r.op == msvf_pkg::OP_TICK) st_nxt = msvf_pkg::BK_TICK;
        else if (req_r.op == msvf_pkg::OP_FADE_REQ ||
                 (req_r.op == msvf_pkg::OP_FADE_BTW && req_r.frames != 16'd0))
          st_nxt = msvf_pkg::BK_DIV;
        else if (req_r.op == msvf_pkg::OP_FADE_BTW) st_nxt = msvf_pkg::BK_IDLE;
        else st_nxt = msvf_pkg::BK_EMIT;
      end
      msvf_pkg::BK_DIV:    if (dcnt_r == '0) st_nxt = msvf_pkg::BK_IDLE;
      msvf_pkg::BK_TICK:   if (32'(ws_r) == SLOTS - 1) st_nxt = msvf_pkg::BK_EMIT;
      msvf_pkg::BK_EMIT:   if (!emit_pending && !res_v_r) st_nxt = msvf_pkg::BK_IDLE;
      default:             st_nxt = msvf_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    q_ready = (st_r == msvf_pkg::BK_IDLE);
  end

  // Find next reported slot at or after es_r.
  always_comb begin
    emit_pending = 1'b0;
    es_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (rep_r[i] && (SW+1)'(i) >= es_r) begin
        emit_pending = 1'b1;
        es_idx = SW'(i);
      end
    end
  end

  assign emit_one = (st_r == msvf_pkg::BK_EMIT) && emit_pending && (!res_v_r || out_ready);
  assign nl_sub   = lvl_r[ws_r];
  assign diff_w   = (LW+2)'(nl_sub) - (LW+2)'(stp_r[ws_r]);
  assign dtrial   = {drem_r[msvf_pkg::FRM_W-1:0], dq_r[DW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= msvf_pkg::BK_IDLE;
      hr_r    <= 4'hF;
      res_v_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        lvl_r[i] <= '0; tgt_r[i] <= '0; stp_r[i] <= '0; ceil_r[i] <= '0;
        cnt_r[i] <= '0; mode_r[i] <= msvf_pkg::FM_NONE;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_we) hr_r <= cfg_wdata;
      // Hold the result until its transfer; load a new one when emitting.
      res_v_r <= emit_one || (res_v_r && !out_ready);
      unique case (st_r)
        msvf_pkg::BK_IDLE: begin
          req_r  <= q_data;
          ws_r   <= '0;
          busy_r <= 1'b0;
          rep_r  <= '0;
          stop_r <= '0;
          es_r   <= '0;
        end
        msvf_pkg::BK_DECODE: begin
          unique case (req_r.op)
            msvf_pkg::OP_SET, msvf_pkg::OP_SET_CEIL: begin
              if (req_r.op == msvf_pkg::OP_SET_CEIL)
                ceil_r[rs] <= ($signed(req_r.ceiling_level) < -8'sd20) ?
                              from_int(8'(req_r.ceiling_level + 8'd20)) : '0;
              lvl_r[rs] <= from_int(req_r.level);
              rep_r[rs] <= 1'b1;
            end
            msvf_pkg::OP_FADE_REQ: begin
              logic signed [LW-1:0] nl, nt;
              logic signed [LW:0]   d;
              nl = ($signed(req_r.first_level) != 8'sd1) ? from_int(req_r.first_level)
                                                         : lvl_r[rs];
              priority if (req_r.fade_mode == msvf_pkg::FM_CEIL) nt = ceil_r[rs];
              else if (req_r.fade_mode == msvf_pkg::FM_MUTE) nt = from_int(8'h81);
              else nt = tgt_r[rs];
              lvl_r[rs]  <= nl;
              tgt_r[rs]  <= nt;
              cnt_r[rs]  <= msvf_pkg::CNT_W'(req_r.frames);
              mode_r[rs] <= req_r.fade_mode;
              d = (LW+1)'(nl) - (LW+1)'(nt);
              dneg_r  <= d[LW];
              dq_r    <= d[LW] ? DW'(-d) : DW'(d);
              drem_r  <= '0;
              dcnt_r  <= DCW'(DW);
              dslot_r <= rs;
            end
            msvf_pkg::OP_FADE_BTW: begin
              logic signed [LW-1:0] nl, nt;
              logic signed [LW:0]   d;
              nl = ($signed(req_r.start_level) == -8'sd1) ?
                   from_int(8'(trunc_i(lvl_r[rs]))) : from_int(req_r.start_level);
              nt = from_int(req_r.end_level);
              lvl_r[rs]  <= nl;
              tgt_r[rs]  <= nt;
              cnt_r[rs]  <= msvf_pkg::CNT_W'(req_r.frames);
              mode_r[rs] <= msvf_pkg::FM_CEIL;
              d = (LW+1)'(nl) - (LW+1)'(nt);
              dneg_r  <= d[LW];
              dq_r    <= d[LW] ? DW'(-d) : DW'(d);
              drem_r  <= '0;
              dcnt_r  <= DCW'(DW);
              dslot_r <= rs;
            end
            default: ;
          endcase
        end
        msvf_pkg::BK_DIV: begin
          // One quotient bit per cycle, restoring.
          if (dcnt_r != '0) begin
            dcnt_r <= dcnt_r - 1'b1;
            if (dtrial >= {1'b0, req_r.frames}) begin
              drem_r <= dtrial - {1'b0, req_r.frames};
              dq_r   <= {dq_r[DW-2:0], 1'b1};
            end else begin
              drem_r <= dtrial;
              dq_r   <= {dq_r[DW-2:0], 1'b0};
            end
          end else begin
            stp_r[dslot_r] <= dneg_r ? LW'(-dq_r) : LW'(dq_r);
          end
        end
        msvf_pkg::BK_TICK: begin
          if (mode_r[ws_r] != msvf_pkg::FM_NONE) begin
            rep_r[ws_r] <= 1'b1;
            cnt_r[ws_r] <= cnt_r[ws_r] - 1'b1;
            if (cnt_r[ws_r] == '0) begin
              lvl_r[ws_r]  <= tgt_r[ws_r];
              mode_r[ws_r] <= msvf_pkg::FM_NONE;
              stop_r[ws_r] <= (trunc_i(tgt_r[ws_r]) == -9'sd127);
            end else begin
              busy_r <= 1'b1;
              if (diff_w < (LW+2)'(LMIN))      lvl_r[ws_r] <= LMIN;
              else if (diff_w > (LW+2)'(LMAX)) lvl_r[ws_r] <= LMAX;
              else                             lvl_r[ws_r] <= LW'(diff_w);
            end
          end
          ws_r <= SW'(ws_r + 1'b1);
        end
        msvf_pkg::BK_EMIT: begin
          if (emit_one) begin
            es_r    <= (SW+1)'(es_idx) + 1'b1;
            res_r.out_slot      <= 2'(es_idx);
            res_r.attenuation   <= att_of(lvl_r[es_idx], es_idx == '0);
            res_r.level_written <= (32'(es_idx) < 4) && hr_r[2'(es_idx)];
            res_r.stop_stream   <= stop_r[es_idx];
            res_r.fade_busy     <= busy_r;
            res_r.last          <= (rep_r & ~((SLOTS'(2) << es_idx) - 1'b1)) == '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = res_v_r;
  assign out_data  = res_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> !res_v_r || st_r == msvf_pkg::BK_IDLE) else $error("ready outside idle");
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && !out_ready) |=> $stable(res_r)) else $error("result overwritten");
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == msvf_pkg::BK_DIV && dcnt_r == '0) |=> st_r == msvf_pkg::BK_IDLE)
    else $error("divider did not finish");

endmodule
`default_nettype wire
